// ===== rtl/core/assert_macros.svh =====
// assertion macros for the ordered list block
// sampled on clk_i, disabled while rst_ni is low; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define OLAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds after the antecedent, by non-overlapping implication
`define OLAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/olad_pkg.sv =====
// shared types and constants for the ordered list block
// used by the channel interfaces, the cells, the cell row and the top level
`timescale 1ns / 1ps

package olad_pkg;

  // list size and derived widths
  localparam int CAPACITY = 32;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int KIND_W   = 2;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 6;
  localparam int CMP_W    = (POS_W > OCC_W) ? POS_W : OCC_W;

  // operation codes of an input item
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LIST   = 2'd2
  } olad_kind_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_APPENDED = 3'd0,
    STATUS_DELETED  = 3'd1,
    STATUS_MISSING  = 3'd2,
    STATUS_EMPTY    = 3'd3,
    STATUS_FULL     = 3'd4,
    STATUS_LISTED   = 3'd5
  } olad_status_e;

  // what the cell row does this cycle
  typedef enum logic [1:0] {
    CH_HOLD   = 2'd0,
    CH_APPEND = 2'd1,
    CH_DELETE = 2'd2,
    CH_ROTATE = 2'd3
  } olad_chain_op_e;

  // control broadcast to every cell
  typedef struct packed {
    olad_chain_op_e           op;
    logic [OCC_W-1:0]         occ;
    logic [OCC_W-1:0]         pos_idx;
    logic signed [WORD_W-1:0] value;
  } olad_chain_ctrl_t;

  // top level sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LIST = 1'b1
  } olad_state_e;

endpackage

// ===== rtl/core/olad_if.sv =====
// valid/ready channel interfaces for operation items and result items
// depends on olad_pkg for field widths
`timescale 1ns / 1ps

interface olad_in_if
  import olad_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [WORD_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

interface olad_out_if
  import olad_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] entry;
  logic                     last;
  logic [FILL_W-1:0]        fill;

  modport source (output valid, status, entry, last, fill, input ready);
  modport sink   (input valid, status, entry, last, fill, output ready);
endinterface

// ===== rtl/core/olad_cell.sv =====
// one list slot: holds a word and decodes the row command for its position
// depends on olad_pkg for the control struct and widths
`timescale 1ns / 1ps

module olad_cell
  import olad_pkg::*;
(
  input  logic                     clk_i,
  input  olad_chain_ctrl_t         ctrl_i,
  input  logic [OCC_W-1:0]         idx_i,
  input  logic signed [WORD_W-1:0] next_i,
  input  logic signed [WORD_W-1:0] head_i,
  output logic signed [WORD_W-1:0] data_o
);

  logic signed [WORD_W-1:0] data_q, data_d;
  logic [OCC_W-1:0]         idx_inc;

  assign idx_inc = idx_i + OCC_W'(1);

  // pick load, shift from neighbor, wrap from head, or hold
  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      CH_APPEND: begin
        if (idx_i == ctrl_i.occ) data_d = ctrl_i.value;
      end
      CH_DELETE: begin
        if (idx_i >= ctrl_i.pos_idx && idx_inc < ctrl_i.occ) data_d = next_i;
      end
      CH_ROTATE: begin
        if (idx_inc < ctrl_i.occ) begin
          data_d = next_i;
        end else if (idx_inc == ctrl_i.occ) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // slot storage, payload only
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/olad_chain.sv =====
// row of list cells, each fed by its upper neighbor and by the head cell
// depends on olad_pkg and olad_cell
`timescale 1ns / 1ps

module olad_chain
  import olad_pkg::*;
(
  input  logic                     clk_i,
  input  olad_chain_ctrl_t         ctrl_i,
  output logic signed [WORD_W-1:0] head_o
);

  logic signed [WORD_W-1:0] cell_data [CAPACITY];

  // cell g takes from cell g+1; the top cell sees its own word
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [WORD_W-1:0] next_w;

    if (g == CAPACITY - 1) begin : g_top
      assign next_w = cell_data[g];
    end else begin : g_mid
      assign next_w = cell_data[g+1];
    end

    olad_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .idx_i  (OCC_W'(g)),
      .next_i (next_w),
      .head_i (cell_data[0]),
      .data_o (cell_data[g])
    );
  end

  assign head_o = cell_data[0];

endmodule

// ===== rtl/core/ordered_list_append_delete_at.sv =====
// top level of the ordered list: sequencer, occupancy, result register
// depends on olad_pkg, olad_if, olad_chain and assert_macros.svh
//
//   channel  dir  fields                          handshake
//   in_i     in   kind, value, position           valid/ready
//   out_o    out  status, entry, last, fill       valid/ready
//
// append and delete give one result each and change the cell row only on success.
// list emits one entry per cycle from the head cell while the row rotates
// inside its held region, unless the result stalls; an empty list gives a
// single empty result.
// reset clears occupancy and control; the slot words are undefined until written.
// a stalled result holds the row and the sequencer; a new item is taken only in
// idle and once the result register is free or being drained.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ordered_list_append_delete_at
  import olad_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  olad_in_if.sink    in_i,
  olad_out_if.source out_o
);

  olad_state_e              state_q, state_d;
  logic [OCC_W-1:0]         occ_q, occ_d;
  logic [OCC_W-1:0]         cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  olad_status_e             out_status_q, out_status_d;
  logic signed [WORD_W-1:0] out_entry_q, out_entry_d;
  logic                     out_last_q, out_last_d;
  logic [FILL_W-1:0]        out_fill_q, out_fill_d;

  olad_chain_ctrl_t         ctrl;
  logic signed [WORD_W-1:0] head;
  logic                     out_free;
  logic                     accept;
  logic [CMP_W-1:0]         pos_ext, occ_ext;
  logic                     list_last;
  logic                     append_room;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && out_free;
  assign accept      = in_i.valid && in_i.ready;
  assign pos_ext     = CMP_W'(in_i.position);
  assign occ_ext     = CMP_W'(occ_q);
  assign list_last   = (cnt_q + OCC_W'(1)) == occ_q;

  // cell row
  olad_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  // sequencer, occupancy and result selection
  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_last_d   = out_last_q;
    out_fill_d   = out_fill_q;
    ctrl.op      = CH_HOLD;
    ctrl.occ     = occ_q;
    ctrl.pos_idx = OCC_W'(in_i.position - POS_W'(1));
    ctrl.value   = in_i.value;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_entry_d = '0;
          out_last_d  = 1'b1;
          out_fill_d  = FILL_W'(occ_q);
          case (olad_kind_e'(in_i.kind))
            KIND_APPEND: begin
              out_valid_d = 1'b1;
              if (occ_q == OCC_W'(CAPACITY)) begin
                out_status_d = STATUS_FULL;
              end else begin
                ctrl.op      = CH_APPEND;
                occ_d        = occ_q + OCC_W'(1);
                out_status_d = STATUS_APPENDED;
                out_fill_d   = FILL_W'(occ_q + OCC_W'(1));
              end
            end
            KIND_DELETE: begin
              out_valid_d = 1'b1;
              if (occ_q == '0) begin
                out_status_d = STATUS_EMPTY;
              end else if (in_i.position == '0 || pos_ext > occ_ext) begin
                out_status_d = STATUS_MISSING;
              end else begin
                ctrl.op      = CH_DELETE;
                occ_d        = occ_q - OCC_W'(1);
                out_status_d = STATUS_DELETED;
                out_fill_d   = FILL_W'(occ_q - OCC_W'(1));
              end
            end
            KIND_LIST: begin
              if (occ_q == '0) begin
                out_valid_d  = 1'b1;
                out_status_d = STATUS_EMPTY;
              end else begin
                state_d = ST_LIST;
                cnt_d   = '0;
              end
            end
            default: begin
              // unused kind: no result; the list and occupancy stay as they are
            end
          endcase
        end
      end
      ST_LIST: begin
        if (out_free) begin
          ctrl.op      = CH_ROTATE;
          out_valid_d  = 1'b1;
          out_status_d = STATUS_LISTED;
          out_entry_d  = head;
          out_last_d   = list_last;
          out_fill_d   = FILL_W'(occ_q);
          cnt_d        = cnt_q + OCC_W'(1);
          if (list_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_last_q   <= out_last_d;
    out_fill_q   <= out_fill_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.entry  = out_entry_q;
  assign out_o.last   = out_last_q;
  assign out_o.fill   = out_fill_q;

  // append accepted with room left
  assign append_room = accept && (in_i.kind == KIND_APPEND) && (occ_q != OCC_W'(CAPACITY));

  // checks
  `OLAD_ASSERT(a_occ_bound, occ_q <= OCC_W'(CAPACITY), "occupancy above capacity")
  `OLAD_ASSERT(a_cnt_in_range, (state_q != ST_LIST) || (cnt_q < occ_q), "list index past fill")
  `OLAD_ASSERT_NEXT(a_append_grows, append_room, occ_q == $past(occ_q) + OCC_W'(1), "append lost")

endmodule
